// ===== design/hbs_pkg.sv =====
// hbs_pkg: shared types and constants for the harmonic bond stretch unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hbs_pkg;

  localparam int DefFracBits = 16;
  localparam logic [46:0] Lim47 = {47{1'b1}};
  localparam logic [62:0] Lim63 = {63{1'b1}};

  // classified bond passed from front to back
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [31:0]        k;
    logic [31:0]        r0;
    logic               s1;
    logic               s2;
    logic               cnt;
    logic               last;
  } bond_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_KE, ST_ENERGY, ST_NUM, ST_DIV, ST_DONE
  } bk_state_t;

endpackage
`default_nettype wire

// ===== design/hbs_front.sv =====
// hbs_front: input stage and two-entry queue of classified bonds
// depends on hbs_pkg
`timescale 1ns / 1ps
`default_nettype none
module hbs_front import hbs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_first_x,
  input  wire logic signed [31:0] in_first_y,
  input  wire logic signed [31:0] in_first_z,
  input  wire logic signed [31:0] in_second_x,
  input  wire logic signed [31:0] in_second_y,
  input  wire logic signed [31:0] in_second_z,
  input  wire logic [31:0]        in_force_const,
  input  wire logic [31:0]        in_rest_length,
  input  wire logic               in_first_selected,
  input  wire logic               in_second_selected,
  input  wire logic               in_last_bond,
  input  wire logic               use_sel,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output bond_t                   q_bond
);

  bond_t       mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  bond_t       b;

  // classify: differences and whether the energy counts
  always_comb begin
    b.dx   = 33'(in_first_x) - 33'(in_second_x);
    b.dy   = 33'(in_first_y) - 33'(in_second_y);
    b.dz   = 33'(in_first_z) - 33'(in_second_z);
    b.k    = in_force_const;
    b.r0   = in_rest_length;
    b.s1   = !use_sel || in_first_selected;
    b.s2   = !use_sel || in_second_selected;
    b.cnt  = !use_sel || in_first_selected || in_second_selected;
    b.last = in_last_bond;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_bond   = mem_r[rp_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem_r[wp_r] <= b;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end

endmodule
`default_nettype wire

// ===== design/hbs_back.sv =====
// hbs_back: sequencer computing distance, energy and force per bond
// depends on hbs_pkg
`timescale 1ns / 1ps
`default_nettype none
module hbs_back import hbs_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire bond_t              q_bond,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      out_force_x,
  output logic signed [47:0]      out_force_y,
  output logic signed [47:0]      out_force_z,
  output logic                    out_apply_first,
  output logic                    out_apply_second,
  output logic [46:0]             out_bond_energy,
  output logic [62:0]             out_energy_total,
  output logic                    out_zero_distance,
  output logic                    out_last_out
);

  // divisor d << FRAC_BITS stays below 2^(34+FRAC_BITS); one extra bit for the shift-in
  localparam int DivW = 35 + FRAC_BITS;

  bk_state_t       st_r, st_nxt;
  bond_t           b_r;
  logic [6:0]      cnt_r;
  logic [1:0]      ax_r;
  logic            ph_r;
  logic [31:0]     mg_r [3];
  logic [66:0]     sq_r;
  logic [33:0]     d_r;
  logic [33:0]     e_r;
  logic            eneg_r;
  logic [65:0]     ke_r;
  logic [67:0]     ew_r;
  logic [97:0]     ewk_r;
  logic [97:0]     num_r;
  logic [DivW-1:0] div_r;
  logic [DivW-1:0] rem_r;
  logic [97:0]     quo_r;
  logic [62:0]     acc_r;
  logic [47:0]     f_r [3];
  logic            ov_r;
  logic            zero_r;
  logic [46:0]     en_r;

  // products and step logic, each multiplier at most 34 by 34 bits
  logic [63:0]     sqp;
  logic [33:0]     trial;
  logic [67:0]     trsq;
  logic            take;
  logic [33:0]     d_fin;
  logic [65:0]     ewp;
  logic [97:0]     ewk_full;
  logic [97:0]     esh;
  logic [64:0]     nump;
  logic [97:0]     num_full;
  logic [DivW-1:0] rsh;
  logic            ge;
  logic [97:0]     quo_nxt;
  logic [47:0]     mag_q;
  logic            fneg;
  logic [47:0]     fsat;
  logic [63:0]     accsum;

  // squaring of one separation component per cycle
  assign sqp = 64'(mg_r[ax_r]) * 64'(mg_r[ax_r]);

  // square root, one result bit per cycle from the top
  assign trial = d_r | (34'd1 << cnt_r);
  assign trsq  = 68'(trial) * 68'(trial);
  assign take  = ({1'b0, trsq} <= {2'b0, sq_r});
  assign d_fin = take ? trial : d_r;

  // energy product e^2 * k in two halves of e^2
  assign ewp      = 66'(ph_r ? ew_r[67:34] : ew_r[33:0]) * 66'(b_r.k);
  assign ewk_full = ewk_r + {ewp[63:0], 34'd0};
  assign esh      = ewk_full >> (2 * FRAC_BITS);

  // force numerator k*e*|v| in two halves of k*e
  assign nump     = 65'(ph_r ? ke_r[65:33] : ke_r[32:0]) * 65'(mg_r[ax_r]);
  assign num_full = num_r + {nump, 33'd0};

  // restoring divide step
  assign rsh     = {rem_r[DivW-2:0], num_r[97]};
  assign ge      = (rsh >= div_r);
  assign quo_nxt = {quo_r[96:0], ge};

  // handshake outputs
  always_comb begin
    q_ready = (st_r == ST_IDLE) && !ov_r;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (q_valid && !ov_r) st_nxt = ST_SQ;
      ST_SQ:     if (ax_r == 2'd2) st_nxt = ST_SQRT;
      ST_SQRT:   if (cnt_r == 7'd0) st_nxt = ST_KE;
      ST_KE:     st_nxt = ST_ENERGY;
      ST_ENERGY: if (ph_r) st_nxt = (d_r == '0) ? ST_DONE : ST_NUM;
      ST_NUM:    if (ph_r) st_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 7'd0) st_nxt = (ax_r == 2'd2) ? ST_DONE : ST_NUM;
      ST_DONE:   st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // signed, saturated force component from the finished quotient
  always_comb begin
    mag_q = (quo_nxt[97:47] != '0) ? 48'h8000_0000_0000 : {1'b0, quo_nxt[46:0]};
    case (ax_r)
      2'd1:    fneg = eneg_r ^ b_r.dy[32];
      2'd2:    fneg = eneg_r ^ b_r.dz[32];
      default: fneg = eneg_r ^ b_r.dx[32];
    endcase
    if (!fneg && mag_q[47]) mag_q = {1'b0, {47{1'b1}}};
    fsat = fneg ? (48'd0 - mag_q) : mag_q;
    if (e_r == '0 || mg_r[ax_r] == '0) fsat = '0;
  end

  assign accsum = {1'b0, acc_r} + 64'(en_r);

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (q_valid && !ov_r) begin
          b_r     <= q_bond;
          mg_r[0] <= q_bond.dx[32] ? 32'(-q_bond.dx) : 32'(q_bond.dx);
          mg_r[1] <= q_bond.dy[32] ? 32'(-q_bond.dy) : 32'(q_bond.dy);
          mg_r[2] <= q_bond.dz[32] ? 32'(-q_bond.dz) : 32'(q_bond.dz);
          ax_r    <= 2'd0;
          sq_r    <= '0;
        end
      end
      ST_SQ: begin
        sq_r  <= sq_r + 67'(sqp);
        ax_r  <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        d_r   <= '0;
        cnt_r <= 7'd33;
      end
      ST_SQRT: begin
        d_r   <= d_fin;
        cnt_r <= cnt_r - 7'd1;
        // e = |d - r0| and its sign once d is final
        if (cnt_r == 7'd0) begin
          if (d_fin >= 34'(b_r.r0)) begin
            e_r    <= d_fin - 34'(b_r.r0);
            eneg_r <= 1'b0;
          end else begin
            e_r    <= 34'(b_r.r0) - d_fin;
            eneg_r <= 1'b1;
          end
        end
      end
      ST_KE: begin
        ke_r <= 66'(e_r) * 66'(b_r.k);
        ew_r <= 68'(e_r) * 68'(e_r);
        ph_r <= 1'b0;
      end
      ST_ENERGY: begin
        ph_r <= ~ph_r;
        if (!ph_r) begin
          ewk_r <= 98'(ewp);
        end else begin
          en_r   <= !b_r.cnt ? '0 : ((esh[97:47] != '0) ? Lim47 : esh[46:0]);
          div_r  <= DivW'(d_r) << FRAC_BITS;
          zero_r <= (d_r == '0);
          ax_r   <= 2'd0;
        end
      end
      ST_NUM: begin
        ph_r <= ~ph_r;
        if (!ph_r) begin
          num_r <= 98'(nump);
        end else begin
          num_r <= num_full << 1;
          rem_r <= '0;
          quo_r <= '0;
          cnt_r <= 7'd97;
        end
      end
      ST_DIV: begin
        num_r <= num_r << 1;
        rem_r <= ge ? (rsh - div_r) : rsh;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 7'd1;
        // last quotient bit: store this axis and move on
        if (cnt_r == 7'd0) begin
          f_r[ax_r] <= fsat;
          if (ax_r != 2'd2) ax_r <= ax_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // output register and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      ov_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (st_r == ST_DONE) begin
        ov_r <= 1'b1;
        out_energy_total  <= accsum[63] ? Lim63 : accsum[62:0];
        acc_r <= b_r.last ? '0 : (accsum[63] ? Lim63 : accsum[62:0]);
        out_bond_energy   <= en_r;
        out_zero_distance <= zero_r;
        out_last_out      <= b_r.last;
        out_apply_first   <= !zero_r && b_r.s1;
        out_apply_second  <= !zero_r && b_r.s2;
        out_force_x <= zero_r ? '0 : f_r[0];
        out_force_y <= zero_r ? '0 : f_r[1];
        out_force_z <= zero_r ? '0 : f_r[2];
      end
    end
  end

  assign out_valid = ov_r;

endmodule
`default_nettype wire

// ===== design/harmonic_bond_stretch_unit.sv =====
// Harmonic bond stretch unit: one bond item per pass of the back-end sequencer.
// An item goes through 3 squaring steps, 34 square-root steps and the energy
// products, then per axis the force numerator products and a 98-step restoring
// divide; the divide sets the rate. When the atoms coincide the axes are skipped.
// The back takes its next bond the cycle after a result is accepted, so it works
// on one bond at a time. A two-entry queue lets the front accept bonds while the
// back is busy. Depends on hbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module harmonic_bond_stretch_unit import hbs_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [1:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_first_x,
  input  wire logic signed [31:0] in_first_y,
  input  wire logic signed [31:0] in_first_z,
  input  wire logic signed [31:0] in_second_x,
  input  wire logic signed [31:0] in_second_y,
  input  wire logic signed [31:0] in_second_z,
  input  wire logic [31:0]        in_force_const,
  input  wire logic [31:0]        in_rest_length,
  input  wire logic               in_first_selected,
  input  wire logic               in_second_selected,
  input  wire logic               in_last_bond,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [47:0]      out_force_x,
  output logic signed [47:0]      out_force_y,
  output logic signed [47:0]      out_force_z,
  output logic                    out_apply_first,
  output logic                    out_apply_second,
  output logic [46:0]             out_bond_energy,
  output logic [62:0]             out_energy_total,
  output logic                    out_zero_distance,
  output logic                    out_last_out
);

  logic  use_sel_r;
  logic  q_valid, q_ready;
  bond_t q_bond;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {31'd0, use_sel_r} : 32'd0;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) use_sel_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      use_sel_r <= cfg_pwdata[0];
  end

  hbs_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_first_x, .in_first_y, .in_first_z,
    .in_second_x, .in_second_y, .in_second_z, .in_force_const, .in_rest_length,
    .in_first_selected, .in_second_selected, .in_last_bond,
    .use_sel(use_sel_r), .q_valid, .q_ready, .q_bond
  );

  hbs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_bond, .out_valid, .out_ready,
    .out_force_x, .out_force_y, .out_force_z, .out_apply_first,
    .out_apply_second, .out_bond_energy, .out_energy_total,
    .out_zero_distance, .out_last_out
  );

endmodule
`default_nettype wire

// ===== design/hbs_checker.sv =====
// hbs_checker: port-level assertions for the bond stretch unit
// depends on harmonic_bond_stretch_unit ports
`timescale 1ns / 1ps
`default_nettype none
module hbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_zero_distance,
  input wire logic        out_apply_first,
  input wire logic [47:0] out_force_x,
  input wire logic [46:0] out_bond_energy,
  input wire logic [62:0] out_energy_total
);
  // coincident atoms give no force
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_distance |-> out_force_x == '0 && !out_apply_first)
    else $error("force on zero distance");
  // total never below this bond's energy
  a_tot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_energy_total >= 63'(out_bond_energy))
    else $error("total below bond energy");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy_total))
    else $error("result dropped");
endmodule

bind harmonic_bond_stretch_unit hbs_checker u_chk (.*);
`default_nettype wire
